### hw/rtl/iac_pkg.sv
// Package with shared widths, request and status codes, and cell control type.
`default_nettype none
package iac_pkg;

    // Fixed field widths of the stream payload.
    localparam int REQ_W  = 2;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int ST_W   = 2;
    localparam int LEN_W  = 7;

    // Packed tdata widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((VAL_W + LEN_W + 7) / 8) * 8;

    // Defaults for the top level parameters.
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_GET    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_SET    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ERASE  = 2'd3;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Commands broadcast to every cell of the chain.
    typedef struct packed {
        logic wr;        // overwrite the addressed cell
        logic shift_up;  // insert: open a gap at the position
        logic shift_dn;  // erase: close the gap at the position
    } t_cell_ctrl;

endpackage
`default_nettype wire

### hw/rtl/indexed_array_insert_erase_top.sv
// Top level of the ordered array with get, set, insert and erase requests.
//
//  Channel  | Direction | tdata (low bit up)                    | tuser
//  ---------+-----------+---------------------------------------+---------------
//  i_s_*    | in        | position[6:0], write_value[38:7], pad | req_type[1:0]
//  o_m_*    | out       | read_value[31:0], length[38:32], pad  | status[1:0]
//
// Every request beat produces exactly one result beat, in the cycle after it is taken.
// A new request is taken in every cycle in which the result register is empty
// or its beat is being taken; the single result register sets that figure.
// All cells compare their own index with the request position and load, shift
// or hold in that same cycle, so inserts and erases cost no more than a get.
// Synchronous active-low reset empties the array and drops the result beat;
// the cell contents are not cleared and are only read below the length.
// A stall on the output holds the result and blocks further requests.
`default_nettype none
module indexed_array_insert_erase_top
    import iac_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    // Request stream.
    input  wire                    i_s_tvalid,
    output logic                   o_s_tready,
    input  wire  [IN_TDATA_W-1:0]  i_s_tdata,   // position[6:0], write_value[38:7]
    input  wire  [REQ_W-1:0]       i_s_tuser,   // req_type[1:0]
    // Result stream.
    output logic                   o_m_tvalid,
    input  wire                    i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata,   // read_value[31:0], length[38:32]
    output logic [ST_W-1:0]        o_m_tuser    // status[1:0]
);

    // Count width holds the full capacity; position compares run at the
    // wider of the count width and the request field width.
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic                  r_ovalid;
    logic [VAL_W-1:0]      r_rval;
    logic [ST_W-1:0]       r_status;
    logic [LEN_W-1:0]      r_len;

    logic                  accept;
    logic [REQ_W-1:0]      req;
    logic [PW-1:0]         pos;
    logic [PW-1:0]         cnt_x;
    logic [DATA_WIDTH-1:0] wdata;
    logic [DATA_WIDTH-1:0] chain_rd;
    logic                  in_rng;
    logic                  ins_rng;
    logic                  full;
    logic [ST_W-1:0]       status;
    logic [VAL_W-1:0]      rval;
    t_cell_ctrl            ctrl;

    assign req   = i_s_tuser;
    assign pos   = PW'(i_s_tdata[POS_W-1:0]);
    assign wdata = DATA_WIDTH'(i_s_tdata[POS_W +: VAL_W]);
    assign cnt_x = PW'(r_count);

    assign in_rng  = (pos < cnt_x);
    assign ins_rng = (pos <= cnt_x);
    assign full    = (r_count == CAP_CNT);

    assign o_s_tready = !r_ovalid || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;

    // Decode the request into a status and the cell commands.
    always_comb begin
        status  = ST_DONE;
        ctrl    = '0;
        n_count = r_count;
        rval    = '0;
        unique case (req)
            REQ_GET: begin
                if (in_rng) begin
                    rval = VAL_W'($signed(chain_rd));
                end else begin
                    status = ST_RANGE;
                end
            end
            REQ_SET: begin
                if (in_rng) begin
                    ctrl.wr = accept;
                end else begin
                    status = ST_RANGE;
                end
            end
            REQ_INSERT: begin
                if (!ins_rng) begin
                    status = ST_RANGE;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    ctrl.shift_up = accept;
                    n_count       = r_count + CW'(1);
                end
            end
            REQ_ERASE: begin
                if (in_rng) begin
                    ctrl.shift_dn = accept;
                    n_count       = r_count - CW'(1);
                end else begin
                    status = ST_RANGE;
                end
            end
            default: begin
                status = ST_RANGE;
            end
        endcase
    end

    iac_chain #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH),
        .PW         (PW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_ctrl  (ctrl),
        .i_pos   (pos),
        .i_wdata (wdata),
        .o_rdata (chain_rd)
    );

    // Control state: length and the result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (accept) begin
                r_count  <= n_count;
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with each accepted request.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rval   <= rval;
            r_status <= status;
            r_len    <= LEN_W'(n_count);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = OUT_TDATA_W'({r_len, r_rval});

endmodule
`default_nettype wire

### hw/rtl/iac_cell.sv
// One storage cell of the chain: holds one entry and shifts with its neighbors.
`default_nettype none
module iac_cell
    import iac_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PW         = POS_W,
    parameter int INDEX      = 0
) (
    input  wire                   i_clk,
    input  wire  t_cell_ctrl      i_ctrl,
    input  wire  [PW-1:0]         i_pos,
    input  wire  [DATA_WIDTH-1:0] i_wdata,
    input  wire  [DATA_WIDTH-1:0] i_left,
    input  wire  [DATA_WIDTH-1:0] i_right,
    output logic [DATA_WIDTH-1:0] o_data,
    output logic [DATA_WIDTH-1:0] o_rd
);

    localparam logic [PW-1:0] MY_IDX = PW'(INDEX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;
    logic                  hit;
    logic                  above;

    assign hit   = (i_pos == MY_IDX);
    assign above = (MY_IDX > i_pos);

    always_comb begin
        n_data = r_data;
        if (i_ctrl.wr && hit) begin
            n_data = i_wdata;
        end else if (i_ctrl.shift_up) begin
            if (hit) begin
                n_data = i_wdata;
            end else if (above) begin
                n_data = i_left;
            end
        end else if (i_ctrl.shift_dn && (hit || above)) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    // Only the addressed cell drives the shared read bus.
    assign o_rd   = hit ? r_data : '0;

endmodule
`default_nettype wire

### hw/rtl/iac_chain.sv
// Row of storage cells wired to their neighbors, with an OR read bus.
`default_nettype none
module iac_chain
    import iac_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int PW         = POS_W
) (
    input  wire                   i_clk,
    input  wire  t_cell_ctrl      i_ctrl,
    input  wire  [PW-1:0]         i_pos,
    input  wire  [DATA_WIDTH-1:0] i_wdata,
    output logic [DATA_WIDTH-1:0] o_rdata
);

    logic [DATA_WIDTH-1:0] q    [CAPACITY];
    logic [DATA_WIDTH-1:0] rd   [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        iac_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .PW         (PW),
            .INDEX      (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (i_ctrl),
            .i_pos   (i_pos),
            .i_wdata (i_wdata),
            .i_left  ((g > 0) ? q[(g > 0) ? g - 1 : 0] : q[g]),
            .i_right ((g < CAPACITY - 1) ? q[(g < CAPACITY - 1) ? g + 1 : g] : q[g]),
            .o_data  (q[g]),
            .o_rd    (rd[g])
        );
    end

    always_comb begin
        o_rdata = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            o_rdata = o_rdata | rd[k];
        end
    end

endmodule
`default_nettype wire

### hw/rtl/iac_checker.sv
// Port-level checker for the array block, bound to the top level.
`default_nettype none
module iac_checker
    import iac_pkg::*;
(
    input wire                   i_clk,
    input wire                   i_rst_n,
    input wire                   i_s_tvalid,
    input wire                   o_s_tready,
    input wire                   o_m_tvalid,
    input wire                   i_m_tready,
    input wire [OUT_TDATA_W-1:0] o_m_tdata,
    input wire [ST_W-1:0]        o_m_tuser
);

    // Reset leaves no result beat pending.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result beat present after reset");

    // A stalled result beat holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled result beat changed");

    // No request is taken while a result beat is stalled.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("request taken over a stalled result");

    // Every accepted request yields a result beat in the next cycle.
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> o_m_tvalid)
        else $error("accepted request produced no result");

    // A failed request reports zero as its read value.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_RANGE || o_m_tuser == ST_FULL)
            |-> o_m_tdata[VAL_W-1:0] == '0)
        else $error("failed request returned a nonzero value");

endmodule

bind indexed_array_insert_erase_top iac_checker u_iac_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
`default_nettype wire
